// ===== design/multichannel_median_ema_filter_top_macros.svh =====
// Assertion helpers shared by the filter modules.
// Both expect clk and rst_n in scope and stay quiet while reset is held.
`ifndef MULTICHANNEL_MEDIAN_EMA_FILTER_TOP_MACROS_SVH
`define MULTICHANNEL_MEDIAN_EMA_FILTER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MMEF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MMEF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/mmef_pkg.sv =====
package mmef_pkg;

    // Defaults for the top-level parameters.
    localparam int CHANNELS_DEFAULT      = 4;
    localparam int FRACTION_BITS_DEFAULT = 8;

    // Field widths.
    localparam int CH_W       = 4;
    localparam int STATUS_W   = 8;
    localparam int MM_W       = 16;
    localparam int TIME_W     = 32;
    localparam int CM_W       = 13;
    localparam int ALPHA_W    = 9;
    localparam int TIMEOUT_W  = 16;
    localparam int DIST_W     = 14;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Stream widths.
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 24;

    // Operation codes carried in the input tuser.
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_READ   = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RANGE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [CM_W-1:0]      MAX_RANGE_RESET = 13'd130;
    localparam logic [ALPHA_W-1:0]   ALPHA_RESET     = 9'd77;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET   = 16'd500;

    // Division by ten of a 16-bit value: (x * 52429) >> 19 is exact.
    localparam logic [16:0] DIV10_RECIP = 17'd52429;
    localparam int          DIV10_SHIFT = 19;

    // Smoothing weight arithmetic, in units of 1/256.
    localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;
    localparam int                 EMA_SHIFT = 8;

    // Invalid distance reading.
    localparam logic [DIST_W-1:0] DIST_INVALID = '1;

    // Queue between the front and back parts.
    localparam int QUEUE_DEPTH = 4;

    // How the back part treats an item.
    typedef enum logic [1:0] {
        ITEM_INVALID = 2'd0,  // channel out of range
        ITEM_QUERY   = 2'd1,  // read, or a sample that failed the check
        ITEM_UPDATE  = 2'd2   // good sample: update the channel state
    } item_kind_t;

    typedef struct packed {
        item_kind_t          kind;
        logic [CH_W-1:0]     channel;
        logic [CM_W-1:0]     cm;
        logic [TIME_W-1:0]   now_ms;
    } item_t;

    typedef struct packed {
        logic [CM_W-1:0]      max_range_cm;
        logic [ALPHA_W-1:0]   smoothing_alpha;
        logic [TIMEOUT_W-1:0] stale_timeout_ms;
    } cfg_t;

endpackage

// ===== design/mmef_front.sv =====
module mmef_front #(
    parameter int CHANNELS = mmef_pkg::CHANNELS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  mmef_pkg::cfg_t                  cfg,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // channel[3:0], range_status[11:4], distance_mm[27:12], now_ms[59:28], zero fill
    input  logic [mmef_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    // operation[0]
    input  logic                            s_axis_tuser,
    output logic                            item_valid,
    input  logic                            item_ready,
    output mmef_pkg::item_t                 item
);
    import mmef_pkg::*;

    logic [CH_W-1:0]     channel;
    logic [STATUS_W-1:0] range_status;
    logic [MM_W-1:0]     distance_mm;
    logic [TIME_W-1:0]   now_ms;
    logic [MM_W+16:0]    scaled;
    logic [CM_W-1:0]     cm;
    logic                channel_ok;
    logic                sample_good;
    item_kind_t          kind;
    logic                valid_reg;
    logic                valid_next;
    item_t               item_reg;
    item_t               item_next;
    logic                take;

    // Unpack the transaction.
    assign channel      = s_axis_tdata[3:0];
    assign range_status = s_axis_tdata[11:4];
    assign distance_mm  = s_axis_tdata[27:12];
    assign now_ms       = s_axis_tdata[59:28];

    // Millimetres to centimetres by reciprocal multiplication.
    assign scaled = {17'd0, distance_mm} * {16'd0, DIV10_RECIP};
    assign cm     = scaled[DIV10_SHIFT+CM_W-1:DIV10_SHIFT];

    // Classify the item for the back part.
    assign channel_ok  = {1'b0, channel} < (CH_W+1)'(CHANNELS);
    assign sample_good = (range_status == '0) && (cm <= cfg.max_range_cm);

    always_comb
    begin
        if (!channel_ok)
        begin
            kind = ITEM_INVALID;
        end
        else if ((s_axis_tuser == OP_SAMPLE) && sample_good)
        begin
            kind = ITEM_UPDATE;
        end
        else
        begin
            kind = ITEM_QUERY;
        end
    end

    // One register stage; it refills in the cycle it drains.
    assign s_axis_tready = !valid_reg || item_ready;
    assign take          = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (take)
        begin
            valid_next        = 1'b1;
            item_next.kind    = kind;
            item_next.channel = channel;
            item_next.cm      = cm;
            item_next.now_ms  = now_ms;
        end
        else if (item_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== design/mmef_queue.sv =====
module mmef_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  mmef_pkg::item_t push_item,
    output logic            pop_valid,
    input  logic            pop_ready,
    output mmef_pkg::item_t pop_item
);
    import mmef_pkg::*;
`include "multichannel_median_ema_filter_top_macros.svh"

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t            entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign push_ready = count_reg != CNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_item   = entry_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    // A lone push grows the fill by one; a lone pop shrinks it by one.
    `MMEF_ASSERT_NEXT(a_queue_grow, push && !pop, count_reg == $past(count_reg) + 1'b1,
        "queue fill did not grow on push")
    `MMEF_ASSERT_NEXT(a_queue_shrink, pop && !push, count_reg == $past(count_reg) - 1'b1,
        "queue fill did not shrink on pop")

endmodule

// ===== design/mmef_back.sv =====
module mmef_back #(
    parameter int CHANNELS      = mmef_pkg::CHANNELS_DEFAULT,
    parameter int FRACTION_BITS = mmef_pkg::FRACTION_BITS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  mmef_pkg::cfg_t                   cfg,
    input  logic                             item_valid,
    output logic                             item_ready,
    input  mmef_pkg::item_t                  item,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // result_channel[3:0], distance_cm[17:4], zero fill
    output logic [mmef_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // sample_accepted[0]
    output logic                             m_axis_tuser
);
    import mmef_pkg::*;
`include "multichannel_median_ema_filter_top_macros.svh"

    localparam int IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SV_W   = CM_W + FRACTION_BITS;
    localparam int PROD_W = SV_W + ALPHA_W + 2;
    localparam int SUM_W  = PROD_W + 1;
    localparam int RND_W  = SV_W + 1;

    // Per-channel state. The median needs only the two most recent values
    // beside the new one, so the oldest history entry is never stored.
    logic [CM_W-1:0]   hist0_reg  [CHANNELS];
    logic [CM_W-1:0]   hist1_reg  [CHANNELS];
    logic [1:0]        count_reg  [CHANNELS];
    logic [SV_W-1:0]   smooth_reg [CHANNELS];
    logic              seeded_reg [CHANNELS];
    logic [TIME_W-1:0] time_reg   [CHANNELS];

    logic [IDX_W-1:0]         idx;
    logic [CM_W-1:0]          h0;
    logic [CM_W-1:0]          h1;
    logic [1:0]               cnt;
    logic [SV_W-1:0]          old_value;
    logic                     old_seeded;
    logic [TIME_W-1:0]        old_time;
    logic [CM_W-1:0]          lo01;
    logic [CM_W-1:0]          hi01;
    logic [CM_W-1:0]          mid_hi;
    logic [CM_W-1:0]          median;
    logic [CM_W-1:0]          pick;
    logic [SV_W-1:0]          fresh;
    logic [ALPHA_W-1:0]       alpha;
    logic signed [SV_W:0]     diff;
    logic signed [PROD_W-1:0] prod;
    logic signed [SUM_W-1:0]  sum;
    logic [SV_W-1:0]          ema;
    logic [SV_W-1:0]          new_value;
    logic                     pop;
    logic                     update;

    // Snapshot stage and output register.
    logic              snap_valid_reg;
    logic              snap_valid_next;
    logic [CH_W-1:0]   snap_channel_reg;
    logic              snap_accepted_reg;
    logic              snap_live_reg;
    logic [SV_W-1:0]   snap_value_reg;
    logic [TIME_W-1:0] snap_now_reg;
    logic [TIME_W-1:0] snap_time_reg;
    logic              snap_live_next;
    logic [SV_W-1:0]   snap_value_next;
    logic [TIME_W-1:0] snap_time_next;
    logic              snap_take;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [CH_W-1:0]   out_channel_reg;
    logic [DIST_W-1:0] out_dist_reg;
    logic [DIST_W-1:0] out_dist_next;
    logic              out_accepted_reg;
    logic [TIME_W-1:0] age;
    logic              in_time;
    logic [RND_W-1:0]  rounded;

    // Handshake between the stages.
    assign snap_take  = snap_valid_reg && (!out_valid_reg || m_axis_tready);
    assign item_ready = !snap_valid_reg || snap_take;
    assign pop        = item_valid && item_ready;
    assign update     = pop && (item.kind == ITEM_UPDATE);

    // Read the channel state.
    assign idx        = item.channel[IDX_W-1:0];
    assign h0         = hist0_reg[idx];
    assign h1         = hist1_reg[idx];
    assign cnt        = count_reg[idx];
    assign old_value  = smooth_reg[idx];
    assign old_seeded = seeded_reg[idx];
    assign old_time   = time_reg[idx];

    // Median of the new value and the two most recent ones.
    assign lo01   = (item.cm < h0) ? item.cm : h0;
    assign hi01   = (item.cm < h0) ? h0 : item.cm;
    assign mid_hi = (hi01 < h1) ? hi01 : h1;
    assign median = (lo01 > mid_hi) ? lo01 : mid_hi;
    assign pick   = (cnt >= 2'd2) ? median : item.cm;
    assign fresh  = {pick, {FRACTION_BITS{1'b0}}};

    // Moving average: old + alpha * (fresh - old) / 256, rounded half up.
    assign alpha = (cfg.smoothing_alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.smoothing_alpha;
    assign diff  = $signed({1'b0, fresh}) - $signed({1'b0, old_value});
    assign prod  = $signed({1'b0, alpha}) * diff;
    assign sum   = $signed({{(SUM_W-SV_W-EMA_SHIFT){1'b0}}, old_value, {EMA_SHIFT{1'b0}}})
                 + SUM_W'(prod)
                 + $signed(SUM_W'(1 << (EMA_SHIFT - 1)));
    assign ema       = sum[SV_W+EMA_SHIFT-1:EMA_SHIFT];
    assign new_value = old_seeded ? ema : fresh;

    // State write on a good sample.
    always_ff @(posedge clk)
    begin
        if (update)
        begin
            hist0_reg[idx]  <= item.cm;
            hist1_reg[idx]  <= h0;
            smooth_reg[idx] <= new_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                count_reg[i]  <= '0;
                seeded_reg[i] <= 1'b0;
                time_reg[i]   <= '0;
            end
        end
        else if (update)
        begin
            count_reg[idx]  <= (cnt == 2'd3) ? cnt : cnt + 1'b1;
            seeded_reg[idx] <= 1'b1;
            time_reg[idx]   <= item.now_ms;
        end
    end

    // Snapshot of the channel as a read would see it after this item.
    always_comb
    begin
        snap_live_next  = 1'b0;
        snap_value_next = old_value;
        snap_time_next  = old_time;
        unique case (item.kind)
            ITEM_UPDATE:
            begin
                snap_live_next  = 1'b1;
                snap_value_next = new_value;
                snap_time_next  = item.now_ms;
            end
            ITEM_QUERY:
            begin
                snap_live_next = old_seeded;
            end
            default:
            begin
                snap_live_next = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        snap_valid_next = snap_valid_reg;
        if (pop)
        begin
            snap_valid_next = 1'b1;
        end
        else if (snap_take)
        begin
            snap_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snap_valid_reg <= 1'b0;
        end
        else
        begin
            snap_valid_reg <= snap_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            snap_channel_reg  <= item.channel;
            snap_accepted_reg <= item.kind == ITEM_UPDATE;
            snap_live_reg     <= snap_live_next;
            snap_value_reg    <= snap_value_next;
            snap_now_reg      <= item.now_ms;
            snap_time_reg     <= snap_time_next;
        end
    end

    // Staleness check and rounding into the output register.
    assign age     = snap_now_reg - snap_time_reg;
    assign in_time = (age[TIME_W-1:TIMEOUT_W] == '0)
                  && (age[TIMEOUT_W-1:0] <= cfg.stale_timeout_ms);
    assign rounded = {1'b0, snap_value_reg} + RND_W'(1 << (FRACTION_BITS - 1));
    assign out_dist_next = (snap_live_reg && in_time)
                         ? rounded[FRACTION_BITS+DIST_W-1:FRACTION_BITS] : DIST_INVALID;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (snap_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (snap_take)
        begin
            out_channel_reg  <= snap_channel_reg;
            out_dist_reg     <= out_dist_next;
            out_accepted_reg <= snap_accepted_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W-DIST_W-CH_W){1'b0}}, out_dist_reg, out_channel_reg};
    assign m_axis_tuser  = out_accepted_reg;

    // A good sample leaves its channel seeded and fresh in the snapshot.
    `MMEF_ASSERT_NEXT(a_update_live, update, snap_live_reg && snap_accepted_reg,
        "good sample did not produce a live snapshot")
    // An accepted sample never reports an invalid distance.
    `MMEF_ASSERT_SAME(a_accepted_valid, out_valid_reg && out_accepted_reg,
        out_dist_reg != DIST_INVALID, "accepted sample reported as invalid")
    // After a good sample the channel's history count is no longer zero.
    `MMEF_ASSERT_NEXT(a_count_after_update, update, count_reg[$past(idx)] != 2'd0,
        "history count still zero after a good sample")

endmodule

// ===== design/multichannel_median_ema_filter_top.sv =====
// Multichannel median-of-three and moving-average range filter.
//
// Input stream (s_axis_*): one transaction per item. tuser selects a new
// sample (0) or a read of the filtered distance (1); tdata carries the
// channel, range status, distance in mm and the current ms time.
// Output stream (m_axis_*): exactly one transaction per input transaction,
// in order, with the channel, the rounded distance in cm (-1 when the
// channel is out of range, unseeded or stale) and the accepted flag.
// Configuration: cfg_wen writes cfg_wdata to register cfg_index (0 maximum
// range, 1 smoothing weight, 2 stale timeout); write only while idle.
//
// Throughput is one item per cycle unless the output stalls: each item reads
// and writes its channel state in the cycle it leaves the queue. An item goes
// through the input register, the queue, the state update and the output
// register to output valid, and waits while the output stalls. A four-entry
// queue between the classifier and the state update absorbs short stalls;
// when the receiver holds tready low the stages fill and s_axis_tready drops.
// Reset clears all channels to unseeded and restores the register defaults.
module multichannel_median_ema_filter_top #(
    parameter int CHANNELS      = mmef_pkg::CHANNELS_DEFAULT,
    parameter int FRACTION_BITS = mmef_pkg::FRACTION_BITS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wen,
    input  logic [mmef_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mmef_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // channel[3:0], range_status[11:4], distance_mm[27:12], now_ms[59:28], zero fill
    input  logic [mmef_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // operation[0]
    input  logic                             s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // result_channel[3:0], distance_cm[17:4], zero fill
    output logic [mmef_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // sample_accepted[0]
    output logic                             m_axis_tuser
);
    import mmef_pkg::*;

    cfg_t  cfg_reg;
    cfg_t  cfg_next;
    logic  front_valid;
    logic  front_ready;
    item_t front_item;
    logic  back_valid;
    logic  back_ready;
    item_t back_item;

    // Configuration register file.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wen)
        begin
            unique case (cfg_index)
                CFG_MAX_RANGE: cfg_next.max_range_cm     = cfg_wdata[CM_W-1:0];
                CFG_ALPHA:     cfg_next.smoothing_alpha  = cfg_wdata[ALPHA_W-1:0];
                CFG_TIMEOUT:   cfg_next.stale_timeout_ms = cfg_wdata[TIMEOUT_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_range_cm     <= MAX_RANGE_RESET;
            cfg_reg.smoothing_alpha  <= ALPHA_RESET;
            cfg_reg.stale_timeout_ms <= TIMEOUT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Classifier.
    mmef_front #(
        .CHANNELS(CHANNELS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .item_valid   (front_valid),
        .item_ready   (front_ready),
        .item         (front_item)
    );

    // Decoupling queue.
    mmef_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_valid(front_valid),
        .push_ready(front_ready),
        .push_item (front_item),
        .pop_valid (back_valid),
        .pop_ready (back_ready),
        .pop_item  (back_item)
    );

    // Channel state update and result.
    mmef_back #(
        .CHANNELS     (CHANNELS),
        .FRACTION_BITS(FRACTION_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .item_valid   (back_valid),
        .item_ready   (back_ready),
        .item         (back_item),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

endmodule

// ===== tb/multichannel_median_ema_filter_top_tb.sv =====
module multichannel_median_ema_filter_top_tb;
    import mmef_pkg::*;

    localparam int NUM_CH           = CHANNELS_DEFAULT;
    localparam int FRAC             = FRACTION_BITS_DEFAULT;
    localparam int NUM_PHASES       = 6;
    localparam int PHASE_ITEMS      = 165;
    localparam int RX_HOLD_CYCLES   = 120;
    localparam int QUIET_LIMIT      = 2000;
    localparam int SHOWN_MISMATCHES = 10;
    localparam int DIRECTED_ROWS    = 23;

    typedef struct packed {
        logic                op;
        logic [CH_W-1:0]     channel;
        logic [STATUS_W-1:0] range_status;
        logic [MM_W-1:0]     distance_mm;
        logic [TIME_W-1:0]   now_ms;
    } range_item_t;

    typedef struct packed {
        logic [CH_W-1:0]   channel;
        logic [DIST_W-1:0] distance_cm;
        logic              accepted;
    } reading_t;

    // A directed row; when known is set the expected reading is typed in.
    typedef struct packed {
        range_item_t       item;
        logic              known;
        logic [DIST_W-1:0] dist_cm;
        logic              acc;
    } directed_row_t;

    // Items with the reset register values: range 130 cm, weight 77, timeout 500 ms.
    localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
        // reads of an unseeded channel and of a channel out of range
        '{'{OP_READ,   4'd0,  8'd0,   16'd0,     32'd0},          1'b1, DIST_INVALID, 1'b0},
        '{'{OP_READ,   4'd15, 8'd0,   16'd0,     32'd0},          1'b1, DIST_INVALID, 1'b0},
        // samples on channels that do not exist are ignored
        '{'{OP_SAMPLE, 4'd15, 8'd0,   16'd100,   32'd10},         1'b1, DIST_INVALID, 1'b0},
        '{'{OP_SAMPLE, 4'd4,  8'd0,   16'd100,   32'd10},         1'b1, DIST_INVALID, 1'b0},
        // seeding with zero and with the largest accepted distance
        '{'{OP_SAMPLE, 4'd0,  8'd0,   16'd0,     32'd100},        1'b1, 14'd0,        1'b1},
        '{'{OP_SAMPLE, 4'd1,  8'd0,   16'd1300,  32'd100},        1'b1, 14'd130,      1'b1},
        '{'{OP_SAMPLE, 4'd1,  8'd0,   16'd1309,  32'd100},        1'b1, 14'd130,      1'b1},
        // one centimetre over the limit is rejected
        '{'{OP_SAMPLE, 4'd1,  8'd0,   16'd1310,  32'd100},        1'b1, 14'd130,      1'b0},
        // bad status codes, then a distance far over the limit
        '{'{OP_SAMPLE, 4'd2,  8'd255, 16'd500,   32'd100},        1'b1, DIST_INVALID, 1'b0},
        '{'{OP_SAMPLE, 4'd2,  8'd1,   16'd500,   32'd100},        1'b1, DIST_INVALID, 1'b0},
        '{'{OP_SAMPLE, 4'd3,  8'd0,   16'd65535, 32'd100},        1'b1, DIST_INVALID, 1'b0},
        // exactly at the timeout, then one millisecond past it
        '{'{OP_READ,   4'd1,  8'd0,   16'd0,     32'd600},        1'b1, 14'd130,      1'b0},
        '{'{OP_READ,   4'd1,  8'd0,   16'd0,     32'd601},        1'b1, DIST_INVALID, 1'b0},
        // history filling up, then the median of three
        '{'{OP_SAMPLE, 4'd0,  8'd0,   16'd100,   32'd200},        1'b0, 14'd0,        1'b0},
        '{'{OP_SAMPLE, 4'd0,  8'd0,   16'd50,    32'd210},        1'b0, 14'd0,        1'b0},
        '{'{OP_SAMPLE, 4'd0,  8'd0,   16'd990,   32'd220},        1'b0, 14'd0,        1'b0},
        '{'{OP_SAMPLE, 4'd0,  8'd0,   16'd9,     32'd230},        1'b0, 14'd0,        1'b0},
        // the age is taken across the wrap of the ms counter
        '{'{OP_SAMPLE, 4'd3,  8'd0,   16'd500,   32'hFFFF_FF00},  1'b1, 14'd50,       1'b1},
        '{'{OP_READ,   4'd3,  8'd0,   16'd0,     32'h0000_00F0},  1'b1, 14'd50,       1'b0},
        '{'{OP_READ,   4'd3,  8'd0,   16'd0,     32'h0000_00F5},  1'b1, DIST_INVALID, 1'b0},
        '{'{OP_READ,   4'd0,  8'd0,   16'd0,     32'd230},        1'b0, 14'd0,        1'b0},
        '{'{OP_SAMPLE, 4'd1,  8'd0,   16'd1300,  32'h8000_0000},  1'b1, 14'd130,      1'b1},
        '{'{OP_READ,   4'd2,  8'd0,   16'd0,     32'hFFFF_FFFF},  1'b1, DIST_INVALID, 1'b0}
    };

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_wen;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;

    // Register copies and per-channel filter state of the predictor.
    logic [CM_W-1:0]      max_range_cm_q;
    logic [ALPHA_W-1:0]   alpha_q;
    logic [TIMEOUT_W-1:0] timeout_q;
    logic [CM_W-1:0]      recent_cm [NUM_CH][3];
    int unsigned          recent_count [NUM_CH];
    longint unsigned      ema_fixed [NUM_CH];
    bit                   ema_seeded [NUM_CH];
    logic [TIME_W-1:0]    last_good_ms [NUM_CH];

    reading_t          pending_readings [$];
    reading_t          observed;
    reading_t          wanted;
    logic [TIME_W-1:0] wall_ms;
    int unsigned       mismatch_count = 0;
    int unsigned       quiet_cycles = 0;
    bit                tx_gaps_on = 1'b0;
    bit                rx_gaps_on = 1'b0;
    bit                rx_hold_req = 1'b0;

    multichannel_median_ema_filter_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wen       (cfg_wen),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock with a period of 8.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Rounded distance of a channel as seen at time now, or the invalid code.
    function automatic logic [DIST_W-1:0] channel_distance(logic [CH_W-1:0] ch,
                                                           logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] age;
        longint unsigned   rounded;
        if (ch >= NUM_CH || !ema_seeded[ch])
            return DIST_INVALID;
        age = now - last_good_ms[ch];
        if (age > timeout_q)
            return DIST_INVALID;
        rounded = (ema_fixed[ch] + (64'd1 << (FRAC - 1))) >> FRAC;
        return rounded[DIST_W-1:0];
    endfunction

    // Applies one accepted item to the channel state and gives its reading.
    function automatic reading_t apply_item(range_item_t it);
        reading_t        r;
        int unsigned     ch;
        logic [MM_W-1:0] cm_full;
        logic [CM_W-1:0] cm;
        logic [CM_W-1:0] lo;
        logic [CM_W-1:0] hi;
        logic [CM_W-1:0] mid;
        longint unsigned weight;
        longint unsigned fresh;
        ch = it.channel;
        r.channel = it.channel;
        r.accepted = 1'b0;
        cm_full = it.distance_mm / 16'd10;
        if (it.op == OP_SAMPLE && ch < NUM_CH && it.range_status == '0
            && cm_full <= max_range_cm_q)
        begin
            cm = cm_full[CM_W-1:0];
            r.accepted = 1'b1;
            recent_cm[ch][2] = recent_cm[ch][1];
            recent_cm[ch][1] = recent_cm[ch][0];
            recent_cm[ch][0] = cm;
            if (recent_count[ch] < 3)
                recent_count[ch]++;
            // Raw value until the history is full, then the middle of three.
            if (recent_count[ch] < 3)
                mid = cm;
            else
            begin
                lo = (recent_cm[ch][0] < recent_cm[ch][1]) ? recent_cm[ch][0] : recent_cm[ch][1];
                hi = (recent_cm[ch][0] < recent_cm[ch][1]) ? recent_cm[ch][1] : recent_cm[ch][0];
                mid = (recent_cm[ch][2] < lo) ? lo : (recent_cm[ch][2] > hi) ? hi : recent_cm[ch][2];
            end
            weight = (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;
            fresh = mid;
            fresh = fresh << FRAC;
            if (!ema_seeded[ch])
            begin
                ema_fixed[ch] = fresh;
                ema_seeded[ch] = 1'b1;
            end
            else
                ema_fixed[ch] = ((ALPHA_ONE - weight) * ema_fixed[ch] + weight * fresh
                                 + (64'd1 << (EMA_SHIFT - 1))) >> EMA_SHIFT;
            last_good_ms[ch] = it.now_ms;
        end
        r.distance_cm = channel_distance(it.channel, it.now_ms);
        return r;
    endfunction

    // Mostly plausible samples and reads on real channels, the rest noise.
    function automatic range_item_t random_item();
        range_item_t it;
        int unsigned pick;
        int unsigned mm_top;
        pick = $urandom_range(0, 99);
        wall_ms = wall_ms + $urandom_range(0, 40);
        it.op = OP_SAMPLE;
        it.channel = CH_W'($urandom_range(0, NUM_CH - 1));
        it.range_status = '0;
        it.distance_mm = '0;
        it.now_ms = wall_ms;
        if (pick < 50)
        begin
            // One sample in ten sits just over the range limit.
            mm_top = max_range_cm_q * 10 + 9;
            if (mm_top > 65535)
                mm_top = 65535;
            if (mm_top < 65535 && $urandom_range(0, 9) == 0)
                it.distance_mm = MM_W'(mm_top + 1);
            else
                it.distance_mm = MM_W'($urandom_range(0, mm_top));
        end
        else if (pick < 80)
        begin
            // Some reads land right on the staleness boundary.
            it.op = OP_READ;
            if (ema_seeded[it.channel] && $urandom_range(0, 2) == 0)
                it.now_ms = last_good_ms[it.channel] + timeout_q + $urandom_range(0, 1);
        end
        else
        begin
            it.op = 1'($urandom_range(0, 1));
            it.channel = CH_W'($urandom_range(0, 15));
            it.range_status = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(0, 255));
            it.distance_mm = MM_W'($urandom);
            it.now_ms = $urandom;
        end
        return it;
    endfunction

    function automatic void note_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= SHOWN_MISMATCHES)
            $display("%s", msg);
    endfunction

    // Offers one item, waits for its transaction and records the expected reading.
    task automatic send_item(range_item_t it, logic known, logic [DIST_W-1:0] dist_cm,
                             logic acc);
        reading_t predicted;
        if (tx_gaps_on && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.op;
        s_axis_tdata  <= {4'd0, it.now_ms, it.distance_mm, it.range_status, it.channel};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predicted = apply_item(it);
        if (known)
        begin
            predicted.distance_cm = dist_cm;
            predicted.accepted = acc;
        end
        pending_readings.push_back(predicted);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
    endtask

    // Writes all three registers on consecutive cycles; the block must be idle.
    task automatic program_filter(logic [CFG_DATA_W-1:0] max_w,
                                  logic [CFG_DATA_W-1:0] alpha_w,
                                  logic [CFG_DATA_W-1:0] timeout_w);
        cfg_wen   <= 1'b1;
        cfg_index <= CFG_MAX_RANGE;
        cfg_wdata <= max_w;
        @(posedge clk);
        cfg_index <= CFG_ALPHA;
        cfg_wdata <= alpha_w;
        @(posedge clk);
        cfg_index <= CFG_TIMEOUT;
        cfg_wdata <= timeout_w;
        @(posedge clk);
        cfg_wen <= 1'b0;
        max_range_cm_q = max_w[CM_W-1:0];
        alpha_q        = alpha_w[ALPHA_W-1:0];
        timeout_q      = timeout_w[TIMEOUT_W-1:0];
    endtask

    // Receiver: random stall bursts, plus one long hold on request.
    initial
    begin
        int unsigned stall_left;
        stall_left = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_req)
            begin
                stall_left = RX_HOLD_CYCLES;
                rx_hold_req = 1'b0;
            end
            else if (stall_left == 0 && rx_gaps_on && $urandom_range(0, 4) == 0)
                stall_left = $urandom_range(1, 8);
            if (stall_left != 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Compare each output transaction with the oldest expected reading.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            observed.channel     = m_axis_tdata[CH_W-1:0];
            observed.distance_cm = m_axis_tdata[CH_W +: DIST_W];
            observed.accepted    = m_axis_tuser;
            if (pending_readings.size() == 0)
                note_mismatch($sformatf("unexpected reading: channel %0d distance %0d accepted %0b",
                                        observed.channel, $signed(observed.distance_cm),
                                        observed.accepted));
            else
            begin
                wanted = pending_readings.pop_front();
                if (observed !== wanted)
                    note_mismatch($sformatf(
                        "reading mismatch: expected ch %0d dist %0d acc %0b, got ch %0d dist %0d acc %0b",
                        wanted.channel, $signed(wanted.distance_cm), wanted.accepted,
                        observed.channel, $signed(observed.distance_cm), observed.accepted));
            end
        end
    end

    // Cycles since the last transaction on either stream.
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        do
            @(posedge clk);
        while (quiet_cycles < QUIET_LIMIT);
        $display("multichannel_median_ema_filter_top test failed");
        $finish;
    end

    // Stimulus: reset, the directed table, then random phases under several settings.
    initial
    begin
        logic [CFG_DATA_W-1:0] max_w;
        logic [CFG_DATA_W-1:0] alpha_w;
        logic [CFG_DATA_W-1:0] timeout_w;
        clk           = 1'b0;
        rst_n         = 1'b0;
        cfg_wen       = 1'b0;
        cfg_index     = '0;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_SAMPLE;
        wall_ms       = '0;
        max_range_cm_q = MAX_RANGE_RESET;
        alpha_q        = ALPHA_RESET;
        timeout_q      = TIMEOUT_RESET;
        for (int c = 0; c < NUM_CH; c++)
        begin
            recent_count[c] = 0;
            ema_fixed[c]    = 0;
            ema_seeded[c]   = 1'b0;
            last_good_ms[c] = '0;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
        for (int i = 0; i < DIRECTED_ROWS; i++)
            send_item(DIRECTED[i].item, DIRECTED[i].known, DIRECTED[i].dist_cm,
                      DIRECTED[i].acc);

        for (int phase = 1; phase <= NUM_PHASES; phase++)
        begin
            wait_drained();
            case (phase)
                1:
                begin
                    // Widest range, full weight, longest timeout; time wraps soon.
                    max_w = 16'hFFFF;
                    alpha_w = 16'd256;
                    timeout_w = 16'hFFFF;
                    wall_ms = 32'hFFFF_FC00;
                end
                2:
                begin
                    // Zero weight keeps the average frozen while time still moves.
                    max_w = 16'd0;
                    alpha_w = 16'd0;
                    timeout_w = 16'd0;
                end
                3:
                begin
                    max_w = 16'd6553;
                    alpha_w = 16'h01FF;
                    timeout_w = 16'd1000;
                end
                4:
                begin
                    max_w = 16'd2000;
                    alpha_w = 16'd1;
                    timeout_w = 16'd65535;
                end
                5:
                begin
                    max_w = CFG_DATA_W'($urandom_range(0, 16'hFFFF));
                    alpha_w = CFG_DATA_W'($urandom_range(0, 16'hFFFF));
                    timeout_w = CFG_DATA_W'($urandom_range(0, 16'hFFFF));
                end
                default:
                begin
                    max_w = CFG_DATA_W'(MAX_RANGE_RESET);
                    alpha_w = CFG_DATA_W'(ALPHA_RESET);
                    timeout_w = CFG_DATA_W'(TIMEOUT_RESET);
                end
            endcase
            program_filter(max_w, alpha_w, timeout_w);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (phase == NUM_PHASES)
                begin
                    tx_gaps_on = 1'b0;
                    rx_gaps_on = 1'b0;
                end
                else if (n % 32 == 0)
                begin
                    tx_gaps_on = ($urandom_range(0, 3) != 0);
                    rx_gaps_on = ($urandom_range(0, 3) != 0);
                end
                // The sender stops until every reading is back.
                if (phase == 2 && n == 60)
                    wait_drained();
                // Long receiver hold while items keep coming, so the input stalls.
                if (phase == 3 && n == 40)
                    rx_hold_req = 1'b1;
                send_item(random_item(), 1'b0, '0, 1'b0);
            end
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && pending_readings.size() == 0)
            $display("multichannel_median_ema_filter_top test passed");
        else
            $display("multichannel_median_ema_filter_top test failed");
        $finish;
    end

endmodule
